// File: rtl/cmdline_flag_value_scanner_defines.svh
`ifndef CMDLINE_FLAG_VALUE_SCANNER_DEFINES_SVH
`define CMDLINE_FLAG_VALUE_SCANNER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CFVS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cfvs: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CFVS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cfvs: next-cycle check failed");

`endif

// File: rtl/cfvs_pkg.sv
package cfvs_pkg;

  localparam int unsigned LINE_MAX_DEF = 256;
  localparam int unsigned KEY_MAX_DEF  = 16;
  localparam int unsigned KEY_BYTES    = 16;
  localparam int unsigned KEY_LEN_W    = 5;
  localparam int unsigned CFG_W        = 64;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LO   = 2'd0,
    CFG_KEY_HI   = 2'd1,
    CFG_KEY_LEN  = 2'd2,
    CFG_LINE_PRS = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] line_char;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [7:0] value_char;
    logic       value_char_valid;
    logic       scan_done;
    logic       flag_found;
    logic       value_found;
    logic [7:0] value_length;
  } out_t;

  typedef struct packed {
    logic [CFG_W-1:0]     key_lo;
    logic [CFG_W-1:0]     key_hi;
    logic [KEY_LEN_W-1:0] key_len;
    logic                 line_present;
  } cfg_t;

endpackage

// File: rtl/cfvs_scan.sv
module cfvs_scan import cfvs_pkg::*; #(
  parameter int unsigned LINE_MAX = LINE_MAX_DEF,
  parameter int unsigned KEY_MAX  = KEY_MAX_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic accept_i,
  input  in_t  in_i,
  input  cfg_t cfg_i,
  output logic res_valid_o,
  output out_t res_o
);

  localparam int unsigned POS_W  = $clog2(LINE_MAX);
  localparam int unsigned TIDX_W = $clog2(KEY_MAX + 2);
  localparam logic [POS_W-1:0]     POS_LAST = POS_W'(LINE_MAX - 1);
  localparam logic [TIDX_W-1:0]    TIDX_TOP = TIDX_W'(KEY_MAX + 1);
  localparam logic [KEY_LEN_W-1:0] KLEN_MAX = KEY_LEN_W'(KEY_MAX);

  typedef enum logic [2:0] {
    PH_BETWEEN,
    PH_KEYPART,
    PH_REST,
    PH_VALUE,
    PH_ENDED
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [TIDX_W-1:0]   tidx_q, tidx_d;
  logic                tmis_q, tmis_d;
  logic                vmis_q, vmis_d;
  logic                flag_q, flag_d;
  logic                vseen_q, vseen_d;
  logic [7:0]          vcnt_q, vcnt_d;

  logic [7:0]           c;
  logic                 ws;
  logic                 line_end;
  logic [KEY_LEN_W-1:0] klen;
  logic [2*CFG_W-1:0]   kvec;

  phase_e               tb_phase;
  logic [TIDX_W-1:0]    tb_idx;
  logic                 tb_tmis;
  logic                 tb_vmis;
  logic [KEY_LEN_W-1:0] tb_pos;
  logic [7:0]           kbyte;
  logic                 kmatch;
  logic                 idx_lt;
  logic                 idx_eq;
  logic                 is_eq;
  logic                 start_tok;
  logic                 do_tb;
  logic                 vvalid;
  logic                 flag_out;

  assign c        = in_i.line_char;
  assign ws       = (c == CHAR_SPACE) || (c == CHAR_TAB);
  assign line_end = (c == CHAR_NUL) || !cfg_i.line_present || (pos_q == POS_LAST);
  assign klen     = (cfg_i.key_len > KLEN_MAX) ? KLEN_MAX : cfg_i.key_len;
  assign kvec     = {cfg_i.key_hi, cfg_i.key_lo};

  assign start_tok = (phase_q == PH_BETWEEN);
  assign tb_phase  = start_tok ? PH_KEYPART : phase_q;
  assign tb_idx    = start_tok ? '0 : tidx_q;
  assign tb_tmis   = start_tok ? 1'b0 : tmis_q;
  assign tb_vmis   = start_tok ? vseen_q : vmis_q;

  assign tb_pos = KEY_LEN_W'(tb_idx);
  assign kbyte  = kvec[{tb_pos[3:0], 3'b000} +: 8];
  assign kmatch = (tb_pos < KLEN_MAX) && (tb_pos < KEY_LEN_W'(KEY_BYTES))
                  && (kbyte != CHAR_NUL) && (kbyte != CHAR_SPACE)
                  && (kbyte != CHAR_TAB) && (kbyte == c);
  assign idx_lt = tb_pos < klen;
  assign idx_eq = tb_pos == klen;
  assign is_eq  = c == CHAR_EQ;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    tidx_d   = tidx_q;
    tmis_d   = tmis_q;
    vmis_d   = vmis_q;
    flag_d   = flag_q;
    vseen_d  = vseen_q;
    vcnt_d   = vcnt_q;
    do_tb    = 1'b0;
    vvalid   = 1'b0;
    flag_out = 1'b0;
    res_o    = '0;

    if (phase_q != PH_ENDED) begin
      if (line_end) begin
        if (phase_q == PH_KEYPART && !tmis_q && KEY_LEN_W'(tidx_q) == klen) begin
          flag_d = 1'b1;
        end
        phase_d = PH_ENDED;
      end else begin
        pos_d = pos_q + 1'b1;
        case (phase_q)
          PH_BETWEEN: begin
            do_tb = !ws;
          end
          PH_KEYPART, PH_REST: begin
            if (ws) begin
              if (phase_q == PH_KEYPART && !tmis_q && KEY_LEN_W'(tidx_q) == klen) begin
                flag_d = 1'b1;
              end
              phase_d = PH_BETWEEN;
            end else begin
              do_tb = 1'b1;
            end
          end
          PH_VALUE: begin
            if (ws) begin
              phase_d = PH_BETWEEN;
            end else begin
              vvalid = 1'b1;
              if (vcnt_q != 8'hFF) begin
                vcnt_d = vcnt_q + 8'd1;
              end
            end
          end
          default: begin
            phase_d = PH_ENDED;
          end
        endcase
      end
    end

    if (do_tb) begin
      phase_d = tb_phase;
      tmis_d  = tb_tmis;
      vmis_d  = tb_vmis | !idx_lt | !kmatch;
      if (tb_phase == PH_KEYPART) begin
        if (is_eq) begin
          if (!tb_tmis && idx_eq) begin
            flag_d = 1'b1;
          end
          phase_d = PH_REST;
        end else if (!idx_lt || !kmatch) begin
          tmis_d = 1'b1;
        end
      end
      if (!tb_vmis && !idx_lt && is_eq) begin
        vseen_d = 1'b1;
        phase_d = PH_VALUE;
      end
      tidx_d = (tb_idx < TIDX_TOP) ? tb_idx + 1'b1 : tb_idx;
    end

    flag_out = flag_d || (phase_d == PH_KEYPART && !tmis_d && KEY_LEN_W'(tidx_d) == klen);

    res_o.value_char       = vvalid ? c : 8'h00;
    res_o.value_char_valid = vvalid;
    res_o.scan_done        = in_i.last_char;
    res_o.flag_found       = in_i.last_char & flag_out;
    res_o.value_found      = in_i.last_char & vseen_d;
    res_o.value_length     = in_i.last_char ? vcnt_d : 8'h00;

    if (in_i.last_char) begin
      phase_d = PH_BETWEEN;
      pos_d   = '0;
      tidx_d  = '0;
      tmis_d  = 1'b0;
      vmis_d  = 1'b0;
      flag_d  = 1'b0;
      vseen_d = 1'b0;
      vcnt_d  = 8'h00;
    end
  end

  assign res_valid_o = accept_i && (vvalid || in_i.last_char);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BETWEEN;
      pos_q   <= '0;
      tidx_q  <= '0;
      tmis_q  <= 1'b0;
      vmis_q  <= 1'b0;
      flag_q  <= 1'b0;
      vseen_q <= 1'b0;
      vcnt_q  <= 8'h00;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      tidx_q  <= tidx_d;
      tmis_q  <= tmis_d;
      vmis_q  <= vmis_d;
      flag_q  <= flag_d;
      vseen_q <= vseen_d;
      vcnt_q  <= vcnt_d;
    end
  end

endmodule

// File: rtl/cmdline_flag_value_scanner.sv
// Command line flag and value scanner.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one line byte per
// request; last_char marks the final byte. The scanner matches each token
// against the configured key and reports both searches in one pass.
// Output channel (out_valid_o / out_stall_i / out_data_o) gives one request for
// every value character and one for the last byte, which carries scan_done,
// flag_found, value_found and value_length. Other bytes give no request.
// Results pass through the output register, and the skid register on a stall.
// Throughput: one byte per cycle unless stalled, set by the scan state update.
// While out_stall_i is high the output register holds its result and one more
// result goes into a skid register; in_stall_o then rises until it drains.
// Configuration (cfg_we_i / cfg_idx_i / cfg_wdata_i) is written only while idle
// by the user; the block does not enforce it. Reset clears the key, key
// length and line-present, restarts the line scan and leaves no request pending.
module cmdline_flag_value_scanner import cfvs_pkg::*; #(
  parameter int unsigned LINE_MAX = LINE_MAX_DEF,
  parameter int unsigned KEY_MAX  = KEY_MAX_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  cfg_t cfg_q, cfg_d;
  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  out_t out_q, out_d;
  out_t skid_q, skid_d;
  logic accept;
  logic res_valid;
  out_t res;

  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY_LO:   cfg_d.key_lo       = cfg_wdata_i;
        CFG_KEY_HI:   cfg_d.key_hi       = cfg_wdata_i;
        CFG_KEY_LEN:  cfg_d.key_len      = cfg_wdata_i[KEY_LEN_W-1:0];
        CFG_LINE_PRS: cfg_d.line_present = cfg_wdata_i[0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  cfvs_scan #(
    .LINE_MAX(LINE_MAX),
    .KEY_MAX (KEY_MAX)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_i       (in_data_i),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_valid_q && out_stall_i) begin
      // hold output, park a new result
      if (res_valid) begin
        skid_valid_d = 1'b1;
        skid_d       = res;
      end
    end else if (skid_valid_q) begin
      out_valid_d  = 1'b1;
      out_d        = skid_q;
      skid_valid_d = 1'b0;
    end else begin
      out_valid_d = res_valid;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q        <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      cfg_q        <= cfg_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

// File: rtl/cfvs_checker.sv
`include "cmdline_flag_value_scanner_defines.svh"

module cfvs_checker import cfvs_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  `CFVS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `CFVS_ASSERT_NOW(a_res_kind, out_valid_o && !out_data_o.scan_done,
                   out_data_o.value_char_valid)
  `CFVS_ASSERT_NOW(a_summary_only_done, out_valid_o && !out_data_o.scan_done,
                   !out_data_o.flag_found && !out_data_o.value_found
                   && out_data_o.value_length == 8'h00)
  `CFVS_ASSERT_NOW(a_char_zero, out_valid_o && !out_data_o.value_char_valid,
                   out_data_o.value_char == 8'h00)
  `CFVS_ASSERT_NOW(a_stall_full, in_stall_o, out_valid_o)

endmodule

bind cmdline_flag_value_scanner cfvs_checker u_cfvs_checker (.*);

// File: tb/sv/cmdline_flag_value_scanner_test.sv
module cmdline_flag_value_scanner_test;
  import cfvs_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1450;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned IDLE_PCT     = 29;
  localparam out_t DONE_EMPTY = '{value_char: 8'h00, value_char_valid: 1'b0, scan_done: 1'b1,
                                  flag_found: 1'b0, value_found: 1'b0, value_length: 8'h00};

  typedef enum logic [2:0] {
    SCAN_GAP, SCAN_KEY, SCAN_REST, SCAN_VALUE, SCAN_ENDED
  } scan_e;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_e;

  typedef struct {
    row_e        kind;
    in_t         item;
    bit          typed;
    out_t        want;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    bit          prs;
  } plan_row_t;

  typedef struct {
    bit   typed;
    out_t want;
  } note_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_t                  in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_t                 out_data_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  cmdline_flag_value_scanner dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  logic [63:0] key_lo   = '0;
  logic [63:0] key_hi   = '0;
  logic [4:0]  key_len  = '0;
  bit          line_on  = 1'b0;

  scan_e       phase    = SCAN_GAP;
  int unsigned pos_cnt  = 0;
  int unsigned tok_idx  = 0;
  bit          tok_miss = 1'b0;
  bit          val_miss = 1'b0;
  bit          flag_hit = 1'b0;
  bit          value_hit = 1'b0;
  logic [7:0]  val_cnt  = '0;

  out_t        pending_out_q[$];
  note_t       note_q[$];
  plan_row_t   plan_q[$];
  logic [7:0]  line_buf[$];
  int unsigned live_cnt = 0;
  int unsigned lines_sent = 0;
  int unsigned cycle_cnt = 0;
  int          fails = 0;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic int unsigned key_len_eff();
    int unsigned n;
    n = key_len;
    return (n > KEY_MAX_DEF) ? KEY_MAX_DEF : n;
  endfunction

  function automatic logic [7:0] key_byte_at(int unsigned p);
    logic [63:0] word;
    word = (p < 8) ? key_lo : key_hi;
    return word[8*(p%8) +: 8];
  endfunction

  function automatic int key_char(int unsigned p);
    logic [7:0] ch;
    if (p >= KEY_MAX_DEF) return 256;
    ch = key_byte_at(p);
    if (ch == CHAR_NUL || ch == CHAR_SPACE || ch == CHAR_TAB) return 256;
    return int'(ch);
  endfunction

  function automatic void close_tok();
    if (phase == SCAN_KEY && !tok_miss && tok_idx == key_len_eff()) flag_hit = 1'b1;
  endfunction

  function automatic void clear_scan();
    phase     = SCAN_GAP;
    pos_cnt   = 0;
    tok_idx   = 0;
    tok_miss  = 1'b0;
    val_miss  = 1'b0;
    flag_hit  = 1'b0;
    value_hit = 1'b0;
    val_cnt   = '0;
  endfunction

  function automatic void tok_byte(logic [7:0] c);
    int unsigned p;
    int unsigned klen;
    bit start_val;
    p = tok_idx;
    klen = key_len_eff();
    start_val = 1'b0;
    if (!val_miss) begin
      if (p < klen) begin
        if (key_char(p) != int'(c)) val_miss = 1'b1;
      end else if (c == CHAR_EQ) begin
        start_val = 1'b1;
      end else begin
        val_miss = 1'b1;
      end
    end
    if (phase == SCAN_KEY) begin
      if (c == CHAR_EQ) begin
        if (!tok_miss && p == klen) flag_hit = 1'b1;
        phase = SCAN_REST;
      end else if (p >= klen || key_char(p) != int'(c)) begin
        tok_miss = 1'b1;
      end
    end
    if (start_val) begin
      value_hit = 1'b1;
      val_miss  = 1'b1;
      phase     = SCAN_VALUE;
    end
    if (tok_idx < KEY_MAX_DEF + 1) tok_idx++;
  endfunction

  function automatic bit scan_byte(input in_t item, output out_t res, output bit live);
    logic [7:0] c;
    bit ws;
    c = item.line_char;
    res = '0;
    live = 1'b0;
    if (phase != SCAN_ENDED) begin
      if (c == CHAR_NUL || !line_on || pos_cnt >= LINE_MAX_DEF - 1) begin
        close_tok();
        phase = SCAN_ENDED;
      end else begin
        live = 1'b1;
        ws = (c == CHAR_SPACE || c == CHAR_TAB);
        pos_cnt++;
        case (phase)
          SCAN_GAP: begin
            if (!ws) begin
              tok_idx  = 0;
              tok_miss = 1'b0;
              val_miss = value_hit;
              phase    = SCAN_KEY;
              tok_byte(c);
            end
          end
          SCAN_KEY, SCAN_REST: begin
            if (ws) begin
              close_tok();
              phase = SCAN_GAP;
            end else begin
              tok_byte(c);
            end
          end
          SCAN_VALUE: begin
            if (ws) begin
              phase = SCAN_GAP;
            end else begin
              res.value_char = c;
              res.value_char_valid = 1'b1;
              if (val_cnt < 8'd255) val_cnt++;
            end
          end
          default: ;
        endcase
      end
    end
    if (item.last_char) begin
      close_tok();
      res.scan_done    = 1'b1;
      res.flag_found   = flag_hit;
      res.value_found  = value_hit;
      res.value_length = val_cnt;
      clear_scan();
      return 1'b1;
    end
    return res.value_char_valid;
  endfunction

  task automatic check_result(out_t want, out_t got);
    if (got.value_char != want.value_char) begin
      $error("value_char: expected %0h, actual %0h", want.value_char, got.value_char);
      fails++;
    end
    if (got.value_char_valid != want.value_char_valid) begin
      $error("value_char_valid: expected %0d, actual %0d",
             want.value_char_valid, got.value_char_valid);
      fails++;
    end
    if (got.scan_done != want.scan_done) begin
      $error("scan_done: expected %0d, actual %0d", want.scan_done, got.scan_done);
      fails++;
    end
    if (got.flag_found != want.flag_found) begin
      $error("flag_found: expected %0d, actual %0d", want.flag_found, got.flag_found);
      fails++;
    end
    if (got.value_found != want.value_found) begin
      $error("value_found: expected %0d, actual %0d", want.value_found, got.value_found);
      fails++;
    end
    if (got.value_length != want.value_length) begin
      $error("value_length: expected %0d, actual %0d", want.value_length, got.value_length);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    note_t note;
    out_t  pred;
    bit    live;
    bit    hit;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        note = note_q.pop_front();
        hit = scan_byte(in_data_i, pred, live);
        if (live) live_cnt++;
        if (note.typed) pending_out_q.push_back(note.want);
        else if (hit) pending_out_q.push_back(pred);
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_out_q.size() == 0) begin
          $error("result with none expected: %0h", out_data_o);
          fails++;
        end else begin
          check_result(pending_out_q.pop_front(), out_data_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic bit pause_now();
    if (live_cnt >= 500 && live_cnt < 800) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  always @(posedge clk_i) out_stall_i <= pause_now();

  task automatic send_byte(in_t item, bit typed, out_t want);
    note_t note;
    while (pause_now()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    note.typed = typed;
    note.want  = want;
    note_q.push_back(note);
    // hold the request until taken
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic configure(logic [63:0] lo, logic [63:0] hi, logic [4:0] len, bit prs);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_out_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_KEY_LO;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_KEY_HI;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_KEY_LEN;
    cfg_wdata_i <= 64'(len);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_LINE_PRS;
    cfg_wdata_i <= 64'(prs);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    key_lo  = lo;
    key_hi  = hi;
    key_len = len;
    line_on = prs;
  endtask

  function automatic void add_cfg(logic [63:0] lo, logic [63:0] hi, logic [4:0] len, bit prs);
    plan_row_t row;
    row = '{kind: ROW_CFG, item: '0, typed: 1'b0, want: '0, lo: lo, hi: hi, len: len, prs: prs};
    plan_q.push_back(row);
  endfunction

  function automatic void add_byte(logic [7:0] c, bit last, bit typed = 1'b0, out_t want = '0);
    plan_row_t row;
    row = '{kind: ROW_BYTE, item: '0, typed: typed, want: want, lo: '0, hi: '0, len: '0,
            prs: 1'b0};
    row.item.line_char = c;
    row.item.last_char = last;
    plan_q.push_back(row);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], i == s.len() - 1);
  endfunction

  function automatic logic [7:0] alpha();
    return 8'h61 + 8'($urandom_range(0, 3));
  endfunction

  function automatic logic [7:0] value_byte();
    logic [7:0] b;
    if ($urandom_range(0, 9) < 7) return alpha();
    b = 8'($urandom_range(1, 255));
    if (b == CHAR_SPACE || b == CHAR_TAB) b = 8'h78;
    return b;
  endfunction

  function automatic void put_key(int unsigned n);
    for (int unsigned i = 0; i < n; i++) line_buf.push_back(key_byte_at(i));
  endfunction

  function automatic void put_value();
    line_buf.push_back(CHAR_EQ);
    repeat ($urandom_range(0, 8)) line_buf.push_back(value_byte());
  endfunction

  function automatic void put_sep();
    repeat ($urandom_range(1, 3)) line_buf.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
  endfunction

  function automatic void put_token();
    int unsigned klen;
    int unsigned r;
    klen = key_len_eff();
    r = $urandom_range(0, 99);
    if (r < 25) begin
      put_key(klen);
    end else if (r < 50) begin
      put_key(klen);
      put_value();
    end else if (r < 58) begin
      put_key((klen > 0) ? $urandom_range(0, klen - 1) : 0);
      if ($urandom_range(0, 1)) put_value();
      else line_buf.push_back(alpha());
    end else if (r < 66) begin
      put_key(klen);
      line_buf.push_back(alpha());
      if ($urandom_range(0, 1)) put_value();
    end else if (r < 74) begin
      put_key(klen);
      if (klen > 0) line_buf[line_buf.size() - 1 - $urandom_range(0, klen - 1)] = alpha();
      if ($urandom_range(0, 1)) put_value();
    end else if (r < 84) begin
      repeat ($urandom_range(1, 6)) line_buf.push_back($urandom_range(0, 4) ? alpha() : CHAR_EQ);
    end else if (r < 92) begin
      put_value();
    end else begin
      repeat ($urandom_range(1, 5)) line_buf.push_back(8'($urandom_range(1, 255)));
    end
  endfunction

  task automatic run_line();
    int unsigned kind;
    int unsigned n_tok;
    int unsigned i;
    bit long_line;
    in_t item;
    line_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 4) begin
      line_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      long_line = (kind < 7) || (lines_sent == 3);
      n_tok = $urandom_range(1, 6);
      if ($urandom_range(0, 3) == 0) put_sep();
      i = 0;
      while (i < n_tok || (long_line && line_buf.size() < 270)) begin
        if (i > 0) put_sep();
        put_token();
        i++;
      end
      if ($urandom_range(0, 9) == 0) begin
        line_buf.push_back(CHAR_NUL);
        repeat ($urandom_range(0, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 7) == 0) begin
        put_sep();
      end
    end
    lines_sent++;
    for (int j = 0; j < line_buf.size(); j++) begin
      item.line_char = line_buf[j];
      item.last_char = (j == line_buf.size() - 1);
      send_byte(item, 1'b0, '0);
    end
  endtask

  task automatic random_config();
    int unsigned r;
    int unsigned n;
    logic [7:0] b;
    logic [127:0] key;
    logic [4:0] len;
    r = $urandom_range(0, 99);
    if (r < 5) len = 5'd0;
    else if (r < 20) len = 5'd16;
    else if (r < 25) len = 5'($urandom_range(17, 31));
    else len = 5'($urandom_range(1, 6));
    n = (len > KEY_MAX_DEF) ? KEY_MAX_DEF : len;
    for (int unsigned i = 0; i < 16; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i < n) begin
        r = $urandom_range(0, 99);
        if (r < 85) b = alpha();
        else if (r < 97) b = 8'($urandom_range(8'h21, 8'hff));
        else b = (r == 97) ? CHAR_NUL : ((r == 98) ? CHAR_TAB : CHAR_SPACE);
      end
      key[8*i +: 8] = b;
    end
    r = $urandom_range(0, 99);
    if (r < 5) key = '1;
    else if (r < 8) key = '0;
    configure(key[63:0], key[127:64], len, $urandom_range(0, 99) < 90);
  endtask

  initial begin
    int unsigned base;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_KEY_LO;
    cfg_wdata_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_byte("k", 1'b1, 1'b1, DONE_EMPTY);
    add_cfg(64'h6261, 64'h0, 5'd2, 1'b1);
    add_text("ab=x ab");
    add_byte("a", 1'b0);
    add_byte(CHAR_NUL, 1'b0);
    add_byte("q", 1'b1, 1'b1, DONE_EMPTY);
    add_byte(8'hff, 1'b0);
    add_byte(CHAR_TAB, 1'b0);
    add_text("ab");
    add_cfg(64'h6261, 64'h0, 5'd31, 1'b1);
    add_text("ab");
    add_cfg(64'h6261, 64'h0, 5'd0, 1'b1);
    add_text("=v");
    add_cfg('1, '1, 5'd1, 1'b1);
    add_byte(8'hff, 1'b0);
    add_byte(CHAR_EQ, 1'b0);
    add_byte(8'hff, 1'b1);

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_CFG) begin
        configure(plan_q[i].lo, plan_q[i].hi, plan_q[i].len, plan_q[i].prs);
      end else begin
        send_byte(plan_q[i].item, plan_q[i].typed, plan_q[i].want);
      end
    end

    base = live_cnt;
    while (live_cnt - base < RANDOM_ITEMS) begin
      random_config();
      repeat ($urandom_range(3, 8)) run_line();
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_out_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fails == 0 && pending_out_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/cfvs_pkg.sv
rtl/cfvs_scan.sv
rtl/cmdline_flag_value_scanner.sv
rtl/cfvs_checker.sv
tb/sv/cmdline_flag_value_scanner_test.sv
